// ----- src/scmr_pkg.sv -----
// Shared types, constants and helper functions of the SCCB register-access master.
package scmr_pkg;

  localparam int TIMER_BITS = 16;
  localparam int LOAD_W     = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  localparam int IN_DEPTH  = 2;
  localparam int OUT_DEPTH = 2;

  localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_HALF_PERIOD    = 2'd1;
  localparam logic [1:0] CFG_GAP            = 2'd2;

  localparam logic [7:0]  DEVICE_ADDRESS_RST = 8'd66;
  localparam logic [15:0] HALF_PERIOD_RST    = 16'd50;
  localparam logic [15:0] GAP_RST            = 16'd100;
  localparam logic [7:0]  READ_ADDR_BIT      = 8'h01;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef enum logic [4:0] {
    P_IDLE, P_START_A, P_START_B, P_WBIT_LO, P_WBIT_HI, P_ACK_LO, P_ACK_HI,
    P_GAP, P_STOP_A, P_STOP_B, P_STOP_C, P_RBIT_LO, P_RBIT_HI,
    P_NACK_A, P_NACK_B, P_NACK_C, P_NACK_D
  } phase_t;

  typedef enum logic [3:0] {
    A_START, A_WID, A_WRID, A_WREG, A_WDATA, A_GAP, A_STOP, A_READ, A_NACK, A_END
  } act_t;

  typedef struct packed {
    logic       request;
    logic       kind;
    logic [7:0] register_address;
    logic [7:0] write_value;
    logic       sda_in;
  } tick_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic       ack_error;
    logic [7:0] read_value;
  } res_t;

  function automatic act_t plan_act(input logic kind, input logic [3:0] step);
    act_t a;
    a = A_END;
    if (kind == KIND_READ) begin
      case (step)
        4'd0:    a = A_START;
        4'd1:    a = A_WID;
        4'd2:    a = A_GAP;
        4'd3:    a = A_WREG;
        4'd4:    a = A_GAP;
        4'd5:    a = A_STOP;
        4'd6:    a = A_GAP;
        4'd7:    a = A_START;
        4'd8:    a = A_WRID;
        4'd9:    a = A_GAP;
        4'd10:   a = A_READ;
        4'd11:   a = A_NACK;
        4'd12:   a = A_STOP;
        default: a = A_END;
      endcase
    end else begin
      case (step)
        4'd0:    a = A_START;
        4'd1:    a = A_WID;
        4'd2:    a = A_GAP;
        4'd3:    a = A_WREG;
        4'd4:    a = A_GAP;
        4'd5:    a = A_WDATA;
        4'd6:    a = A_STOP;
        default: a = A_END;
      endcase
    end
    return a;
  endfunction

  function automatic logic [TIMER_BITS-1:0] load_of(input logic [15:0] dur);
    logic [LOAD_W-1:0] v;
    logic [LOAD_W-1:0] tmask;
    tmask = LOAD_W'({TIMER_BITS{1'b1}});
    v = (dur == 16'd0) ? '0 : (LOAD_W'(dur) - LOAD_W'(1));
    if (v > tmask) begin
      v = tmask;
    end
    return v[TIMER_BITS-1:0];
  endfunction

endpackage

// ----- src/scmr_front.sv -----
// Front end: accepts tick words into a short queue ahead of the bus sequencer.
module scmr_front import scmr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic       in_request,
  input  logic       in_kind,
  input  logic [7:0] in_register_address,
  input  logic [7:0] in_write_value,
  input  logic       in_sda_in,
  input  logic       take,
  output logic       valid,
  output tick_t      tick
);

  localparam int IW = $clog2(IN_DEPTH);

  tick_t            q_r [IN_DEPTH];
  logic [IW-1:0]    wp_r, wp_nxt;
  logic [IW-1:0]    rp_r, rp_nxt;
  logic [IW:0]      cnt_r, cnt_nxt;
  logic             wr, rd;
  tick_t            word;

  assign full  = (cnt_r == (IW+1)'(IN_DEPTH));
  assign valid = (cnt_r != '0);
  assign wr    = push && !full;
  assign rd    = take && valid;
  assign tick  = q_r[rp_r];

  always_comb begin
    word.request          = in_request;
    word.kind             = in_kind;
    word.register_address = in_register_address;
    word.write_value      = in_write_value;
    word.sda_in           = in_sda_in;
    wp_nxt  = wr ? wp_r + IW'(1) : wp_r;
    rp_nxt  = rd ? rp_r + IW'(1) : rp_r;
    cnt_nxt = cnt_r + (IW+1)'(wr) - (IW+1)'(rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q_r[wp_r] <= word;
    end
  end

endmodule

// ----- src/scmr_seq.sv -----
// Back end: SCCB bus sequencer, one tick word per step, with its configuration registers.
module scmr_seq import scmr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        tick_valid,
  input  tick_t       tick,
  output logic        tick_take,
  input  logic        res_room,
  output logic        res_wr,
  output res_t        res
);

  logic [7:0]            dev_r;
  logic [15:0]           half_r;
  logic [15:0]           gap_r;

  phase_t                phase_r, phase_nxt, c_phase, tgt;
  logic [TIMER_BITS-1:0] timer_r, timer_nxt, c_timer;
  logic [3:0]            bit_r, bit_nxt;
  logic [7:0]            shift_r, shift_nxt, shift_a;
  logic                  err_r, err_nxt, c_err;
  logic                  kind_r, kind_nxt, c_kind;
  logic [7:0]            reg_r, reg_nxt, c_reg;
  logic [7:0]            val_r, val_nxt, c_val;
  logic [3:0]            seq_r, seq_nxt, c_seq;
  logic                  scl_r, scl_nxt, c_scl;
  logic                  sda_r, sda_nxt, c_sda;
  logic                  first_r, first_nxt, c_first;

  logic                  step, start, drive, tmr_zero, do_enter, next_act, done_now;
  act_t                  act;

  assign step      = tick_valid && res_room;
  assign tick_take = step;
  assign res_wr    = step;

  always_comb begin
    start   = (phase_r == P_IDLE) && tick.request;
    c_phase = phase_r;
    c_timer = timer_r;
    c_scl   = scl_r;
    c_sda   = sda_r;
    c_kind  = kind_r;
    c_reg   = reg_r;
    c_val   = val_r;
    c_seq   = seq_r;
    c_err   = err_r;
    c_first = first_r;
    if (start) begin
      c_phase = P_START_A;
      c_timer = load_of(half_r);
      c_scl   = 1'b1;
      c_sda   = 1'b1;
      c_kind  = tick.kind;
      c_reg   = tick.register_address;
      c_val   = tick.write_value;
      c_seq   = '0;
      c_err   = 1'b0;
      c_first = 1'b1;
    end

    drive = !(c_phase == P_ACK_LO || c_phase == P_ACK_HI ||
              c_phase == P_RBIT_LO || c_phase == P_RBIT_HI);
    tmr_zero = (c_timer == '0);

    shift_a = shift_r;
    if (c_phase == P_RBIT_HI && c_first) begin
      shift_a = {shift_r[6:0], tick.sda_in};
    end

    phase_nxt = c_phase;
    timer_nxt = c_timer;
    bit_nxt   = bit_r;
    shift_nxt = shift_a;
    err_nxt   = c_err | (c_phase == P_ACK_HI && tmr_zero && c_kind == KIND_WRITE &&
                         tick.sda_in);
    kind_nxt  = c_kind;
    reg_nxt   = c_reg;
    val_nxt   = c_val;
    seq_nxt   = c_seq;
    scl_nxt   = c_scl;
    sda_nxt   = c_sda;
    first_nxt = 1'b0;
    tgt       = P_IDLE;
    do_enter  = 1'b0;
    next_act  = 1'b0;
    done_now  = 1'b0;
    act       = A_END;

    if (c_phase == P_IDLE) begin
      first_nxt = c_first;
      err_nxt   = c_err;
    end else if (!tmr_zero) begin
      timer_nxt = c_timer - TIMER_BITS'(1);
    end else begin
      case (c_phase)
        P_START_A: begin
          tgt = P_START_B;
          do_enter = 1'b1;
        end
        P_WBIT_LO: begin
          tgt = P_WBIT_HI;
          do_enter = 1'b1;
        end
        P_WBIT_HI: begin
          shift_nxt = {shift_a[6:0], 1'b0};
          bit_nxt   = bit_r + 4'd1;
          tgt       = bit_nxt[3] ? P_ACK_LO : P_WBIT_LO;
          do_enter  = 1'b1;
        end
        P_ACK_LO: begin
          tgt = P_ACK_HI;
          do_enter = 1'b1;
        end
        P_STOP_A: begin
          tgt = P_STOP_B;
          do_enter = 1'b1;
        end
        P_STOP_B: begin
          tgt = P_STOP_C;
          do_enter = 1'b1;
        end
        P_RBIT_LO: begin
          tgt = P_RBIT_HI;
          do_enter = 1'b1;
        end
        P_RBIT_HI: begin
          bit_nxt = bit_r + 4'd1;
          if (bit_nxt[3]) begin
            next_act = 1'b1;
          end else begin
            tgt = P_RBIT_LO;
            do_enter = 1'b1;
          end
        end
        P_NACK_A: begin
          tgt = P_NACK_B;
          do_enter = 1'b1;
        end
        P_NACK_B: begin
          tgt = P_NACK_C;
          do_enter = 1'b1;
        end
        P_NACK_C: begin
          tgt = P_NACK_D;
          do_enter = 1'b1;
        end
        default: begin
          next_act = 1'b1;
        end
      endcase
    end

    if (next_act) begin
      seq_nxt = c_seq + 4'd1;
      act     = plan_act(c_kind, seq_nxt);
      case (act)
        A_START: begin
          tgt = P_START_A;
          do_enter = 1'b1;
        end
        A_WID: begin
          shift_nxt = dev_r;
          bit_nxt   = '0;
          tgt       = P_WBIT_LO;
          do_enter  = 1'b1;
        end
        A_WRID: begin
          shift_nxt = dev_r | READ_ADDR_BIT;
          bit_nxt   = '0;
          tgt       = P_WBIT_LO;
          do_enter  = 1'b1;
        end
        A_WREG: begin
          shift_nxt = c_reg;
          bit_nxt   = '0;
          tgt       = P_WBIT_LO;
          do_enter  = 1'b1;
        end
        A_WDATA: begin
          shift_nxt = c_val;
          bit_nxt   = '0;
          tgt       = P_WBIT_LO;
          do_enter  = 1'b1;
        end
        A_GAP: begin
          tgt = P_GAP;
          do_enter = 1'b1;
        end
        A_STOP: begin
          tgt = P_STOP_A;
          do_enter = 1'b1;
        end
        A_READ: begin
          shift_nxt = '0;
          bit_nxt   = '0;
          tgt       = P_RBIT_LO;
          do_enter  = 1'b1;
        end
        A_NACK: begin
          tgt = P_NACK_A;
          do_enter = 1'b1;
        end
        default: begin
          phase_nxt = P_IDLE;
          timer_nxt = '0;
          done_now  = 1'b1;
        end
      endcase
    end

    if (do_enter) begin
      phase_nxt = tgt;
      first_nxt = 1'b1;
      timer_nxt = load_of((tgt == P_GAP) ? gap_r : half_r);
      case (tgt)
        P_START_A: begin
          scl_nxt = 1'b1;
          sda_nxt = 1'b1;
        end
        P_START_B: begin
          scl_nxt = 1'b1;
          sda_nxt = 1'b0;
        end
        P_WBIT_LO: begin
          scl_nxt = 1'b0;
          sda_nxt = shift_nxt[7];
        end
        P_WBIT_HI, P_ACK_HI, P_RBIT_HI, P_STOP_B: begin
          scl_nxt = 1'b1;
        end
        P_ACK_LO, P_RBIT_LO, P_NACK_C: begin
          scl_nxt = 1'b0;
        end
        P_STOP_A, P_NACK_D: begin
          sda_nxt = 1'b0;
        end
        P_STOP_C: begin
          sda_nxt = 1'b1;
        end
        P_NACK_B: begin
          scl_nxt = 1'b1;
          sda_nxt = 1'b1;
        end
        default: begin
          scl_nxt = c_scl;
        end
      endcase
    end
  end

  always_comb begin
    if (c_phase == P_IDLE) begin
      res.scl       = 1'b1;
      res.sda_out   = 1'b1;
      res.sda_drive = 1'b1;
      res.busy_res  = 1'b0;
    end else begin
      res.scl       = c_scl;
      res.sda_out   = drive && c_sda;
      res.sda_drive = drive;
      res.busy_res  = 1'b1;
    end
    res.done_res   = done_now;
    res.ack_error  = done_now && (c_kind == KIND_WRITE) && err_nxt;
    res.read_value = (done_now && c_kind == KIND_READ) ? shift_nxt : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_r   <= DEVICE_ADDRESS_RST;
      half_r  <= HALF_PERIOD_RST;
      gap_r   <= GAP_RST;
      phase_r <= P_IDLE;
      timer_r <= '0;
      bit_r   <= '0;
      shift_r <= '0;
      err_r   <= 1'b0;
      kind_r  <= 1'b0;
      reg_r   <= '0;
      val_r   <= '0;
      seq_r   <= '0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      first_r <= 1'b0;
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          CFG_DEVICE_ADDRESS: dev_r  <= cfg_wdata[7:0];
          CFG_HALF_PERIOD:    half_r <= cfg_wdata;
          CFG_GAP:            gap_r  <= cfg_wdata;
          default:            dev_r  <= dev_r;
        endcase
      end
      if (step) begin
        phase_r <= phase_nxt;
        timer_r <= timer_nxt;
        bit_r   <= bit_nxt;
        shift_r <= shift_nxt;
        err_r   <= err_nxt;
        kind_r  <= kind_nxt;
        reg_r   <= reg_nxt;
        val_r   <= val_nxt;
        seq_r   <= seq_nxt;
        scl_r   <= scl_nxt;
        sda_r   <= sda_nxt;
        first_r <= first_nxt;
      end
    end
  end

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && done_now |=> phase_r == P_IDLE)
    else $error("sequencer not idle after finishing a transaction");

  a_read_phases: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == P_RBIT_LO || phase_r == P_RBIT_HI || phase_r == P_NACK_A ||
     phase_r == P_NACK_D) |-> kind_r == KIND_READ)
    else $error("read-only bus phase during a write");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(phase_r) && $stable(timer_r))
    else $error("sequencer advanced without a tick word");

  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_r[3] |-> bit_r[2:0] == 3'd0)
    else $error("bit counter beyond eight");

endmodule

// ----- src/scmr_outq.sv -----
// Result queue between the bus sequencer and the result ports.
module scmr_outq import scmr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr,
  input  res_t wdata,
  output logic room,
  input  logic pop,
  output logic empty,
  output res_t rdata
);

  localparam int IW = $clog2(OUT_DEPTH);

  res_t          q_r [OUT_DEPTH];
  logic [IW-1:0] wp_r, wp_nxt;
  logic [IW-1:0] rp_r, rp_nxt;
  logic [IW:0]   cnt_r, cnt_nxt;
  logic          wen, rd;

  assign room  = (cnt_r != (IW+1)'(OUT_DEPTH));
  assign empty = (cnt_r == '0);
  assign wen   = wr && room;
  assign rd    = pop && !empty;
  assign rdata = q_r[rp_r];

  always_comb begin
    wp_nxt  = wen ? wp_r + IW'(1) : wp_r;
    rp_nxt  = rd ? rp_r + IW'(1) : rp_r;
    cnt_nxt = cnt_r + (IW+1)'(wen) - (IW+1)'(rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      q_r[wp_r] <= wdata;
    end
  end

endmodule

// ----- src/sccb_master_register_access_top.sv -----
// SCCB register-access master: each input word is one bus tick and yields one result word
// with the line levels and status for that tick. The block takes one word every clock cycle
// when the result side keeps popping; a pushed word is held in the two-entry input queue
// until the sequencer takes it, and its result is written into the two-entry result queue
// that drives the out_ ports. Configuration writes take effect at once and are meant for
// idle periods; every bus phase lasts half_period_ticks ticks and every byte gap gap_ticks
// ticks, a value of zero acting as one tick.
module sccb_master_register_access_top import scmr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        push,
  output logic        full,
  input  logic        in_request,
  input  logic        in_kind,
  input  logic [7:0]  in_register_address,
  input  logic [7:0]  in_write_value,
  input  logic        in_sda_in,
  output logic        empty,
  input  logic        pop,
  output logic        out_scl,
  output logic        out_sda_out,
  output logic        out_sda_drive,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic        out_ack_error,
  output logic [7:0]  out_read_value
);

  tick_t tick;
  logic  tick_valid, tick_take;
  logic  res_room, res_wr;
  res_t  res, res_q;

  scmr_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .push                (push),
    .full                (full),
    .in_request          (in_request),
    .in_kind             (in_kind),
    .in_register_address (in_register_address),
    .in_write_value      (in_write_value),
    .in_sda_in           (in_sda_in),
    .take                (tick_take),
    .valid               (tick_valid),
    .tick                (tick)
  );

  scmr_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .tick_valid (tick_valid),
    .tick       (tick),
    .tick_take  (tick_take),
    .res_room   (res_room),
    .res_wr     (res_wr),
    .res        (res)
  );

  scmr_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (res_wr),
    .wdata (res),
    .room  (res_room),
    .pop   (pop),
    .empty (empty),
    .rdata (res_q)
  );

  assign out_scl        = res_q.scl;
  assign out_sda_out    = res_q.sda_out;
  assign out_sda_drive  = res_q.sda_drive;
  assign out_busy_res   = res_q.busy_res;
  assign out_done_res   = res_q.done_res;
  assign out_ack_error  = res_q.ack_error;
  assign out_read_value = res_q.read_value;

endmodule

// ----- sim/tb.sv -----
// Self-checking bench for the SCCB register-access master: predicted tick results vs. DUT.
module tb import scmr_pkg::*;;

  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  localparam int SDA_LOW        = 0;
  localparam int SDA_HIGH       = 1;
  localparam int SDA_RAND       = 2;
  localparam int SDA_MOSTLY_LOW = 3;
  localparam int SDA_MOSTLY_HIGH = 4;

  localparam int HOLD_LEN   = 200;
  localparam int RAND_PHASES = 3;
  localparam int RAND_ITEMS  = 24;
  localparam int LIMIT_CYCLES = 500000;

  localparam act_t WR_PLAN [0:7] = '{A_START, A_WID, A_GAP, A_WREG, A_GAP, A_WDATA, A_STOP,
                                     A_END};
  localparam act_t RD_PLAN [0:13] = '{A_START, A_WID, A_GAP, A_WREG, A_GAP, A_STOP, A_GAP,
                                      A_START, A_WRID, A_GAP, A_READ, A_NACK, A_STOP, A_END};

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_wen = 1'b0;
  logic [1:0]  cfg_index = CFG_DEVICE_ADDRESS;
  logic [15:0] cfg_wdata = 16'd0;
  logic        push = 1'b0;
  logic        full;
  logic        in_request = 1'b0;
  logic        in_kind = KIND_WRITE;
  logic [7:0]  in_register_address = 8'd0;
  logic [7:0]  in_write_value = 8'd0;
  logic        in_sda_in = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic        out_scl;
  logic        out_sda_out;
  logic        out_sda_drive;
  logic        out_busy_res;
  logic        out_done_res;
  logic        out_ack_error;
  logic [7:0]  out_read_value;

  sccb_master_register_access_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wen(cfg_wen),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .push(push),
    .full(full),
    .in_request(in_request),
    .in_kind(in_kind),
    .in_register_address(in_register_address),
    .in_write_value(in_write_value),
    .in_sda_in(in_sda_in),
    .empty(empty),
    .pop(pop),
    .out_scl(out_scl),
    .out_sda_out(out_sda_out),
    .out_sda_drive(out_sda_drive),
    .out_busy_res(out_busy_res),
    .out_done_res(out_done_res),
    .out_ack_error(out_ack_error),
    .out_read_value(out_read_value)
  );

  tick_t pending_ticks [$];
  res_t  expected_ticks [$];
  int    idle_mode = IDLE_NONE;
  int    mismatches = 0;
  int    words_seen = 0;
  int    hold_left = 0;
  int    hold_at = -1;
  int    txn_done = 0;
  int    txn_reads = 0;
  int    txn_ack_err = 0;

  // bus sequencer copy
  logic [7:0]  dev_addr = DEVICE_ADDRESS_RST;
  logic [15:0] half_len = HALF_PERIOD_RST;
  logic [15:0] gap_len  = GAP_RST;
  phase_t      ph = P_IDLE;
  logic [3:0]  bit_cnt = '0;
  logic [15:0] ptimer = '0;
  logic [7:0]  shreg = '0;
  logic        err = 1'b0;
  logic        hk = KIND_WRITE;
  logic [7:0]  hreg = '0;
  logic [7:0]  hval = '0;
  logic [3:0]  step = '0;
  logic        lscl = 1'b1;
  logic        lsda = 1'b1;
  logic        first = 1'b0;
  logic        done = 1'b0;

  function automatic logic [15:0] phase_span(input logic [15:0] dur);
    return (dur == 16'd0) ? 16'd0 : dur - 16'd1;
  endfunction

  function automatic void enter_phase(input phase_t p);
    ph = p;
    first = 1'b1;
    ptimer = phase_span((p == P_GAP) ? gap_len : half_len);
    case (p)
      P_START_A: begin lscl = 1'b1; lsda = 1'b1; end
      P_START_B: begin lscl = 1'b1; lsda = 1'b0; end
      P_WBIT_LO: begin lscl = 1'b0; lsda = shreg[7]; end
      P_WBIT_HI, P_ACK_HI, P_RBIT_HI: lscl = 1'b1;
      P_ACK_LO, P_RBIT_LO: lscl = 1'b0;
      P_STOP_A: lsda = 1'b0;
      P_STOP_B: lscl = 1'b1;
      P_STOP_C: lsda = 1'b1;
      P_NACK_B: begin lscl = 1'b1; lsda = 1'b1; end
      P_NACK_C: lscl = 1'b0;
      P_NACK_D: lsda = 1'b0;
      default: ;
    endcase
  endfunction

  function automatic void load_byte(input logic [7:0] b);
    shreg = b;
    bit_cnt = '0;
    enter_phase(P_WBIT_LO);
  endfunction

  function automatic void run_action();
    act_t a;
    if (hk == KIND_READ) a = (step < 4'd14) ? RD_PLAN[step] : A_END;
    else a = (step < 4'd8) ? WR_PLAN[step] : A_END;
    case (a)
      A_START: enter_phase(P_START_A);
      A_WID:   load_byte(dev_addr);
      A_WRID:  load_byte(dev_addr | READ_ADDR_BIT);
      A_WREG:  load_byte(hreg);
      A_WDATA: load_byte(hval);
      A_GAP:   enter_phase(P_GAP);
      A_STOP:  enter_phase(P_STOP_A);
      A_READ: begin
        shreg = '0;
        bit_cnt = '0;
        enter_phase(P_RBIT_LO);
      end
      A_NACK:  enter_phase(P_NACK_A);
      default: begin
        ph = P_IDLE;
        ptimer = '0;
        done = 1'b1;
      end
    endcase
  endfunction

  function automatic void next_action();
    step = step + 4'd1;
    run_action();
  endfunction

  function automatic void close_phase();
    case (ph)
      P_START_A: enter_phase(P_START_B);
      P_WBIT_LO: enter_phase(P_WBIT_HI);
      P_WBIT_HI: begin
        shreg = {shreg[6:0], 1'b0};
        bit_cnt = bit_cnt + 4'd1;
        enter_phase((bit_cnt >= 4'd8) ? P_ACK_LO : P_WBIT_LO);
      end
      P_ACK_LO:  enter_phase(P_ACK_HI);
      P_STOP_A:  enter_phase(P_STOP_B);
      P_STOP_B:  enter_phase(P_STOP_C);
      P_RBIT_LO: enter_phase(P_RBIT_HI);
      P_RBIT_HI: begin
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt >= 4'd8) next_action();
        else enter_phase(P_RBIT_LO);
      end
      P_NACK_A:  enter_phase(P_NACK_B);
      P_NACK_B:  enter_phase(P_NACK_C);
      P_NACK_C:  enter_phase(P_NACK_D);
      default:   next_action();
    endcase
  endfunction

  function automatic res_t bus_tick(input tick_t t);
    res_t r;
    logic drv;
    done = 1'b0;
    if (ph == P_IDLE && t.request) begin
      hk = t.kind;
      hreg = t.register_address;
      hval = t.write_value;
      err = 1'b0;
      step = '0;
      run_action();
    end
    if (ph == P_IDLE) begin
      r = '0;
      r.scl = 1'b1;
      r.sda_out = 1'b1;
      r.sda_drive = 1'b1;
      return r;
    end
    drv = !(ph == P_ACK_LO || ph == P_ACK_HI || ph == P_RBIT_LO || ph == P_RBIT_HI);
    r.scl = lscl;
    r.sda_out = drv ? lsda : 1'b0;
    r.sda_drive = drv;
    if (ph == P_RBIT_HI && first) shreg = {shreg[6:0], t.sda_in};
    if (ph == P_ACK_HI && ptimer == 16'd0 && hk == KIND_WRITE && t.sda_in) err = 1'b1;
    first = 1'b0;
    if (ptimer == 16'd0) close_phase();
    else ptimer = ptimer - 16'd1;
    r.busy_res = 1'b1;
    r.done_res = done;
    r.ack_error = (done && hk == KIND_WRITE) ? err : 1'b0;
    r.read_value = (done && hk == KIND_READ) ? shreg : 8'd0;
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin : drive_words
    tick_t seen;
    tick_t nxt;
    res_t  want;
    int    gap_pct;
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      gap_pct = (idle_mode == IDLE_SEND) ? 71 : (idle_mode == IDLE_BOTH) ? 9 : 0;
      if (push && !full) begin
        seen = {in_request, in_kind, in_register_address, in_write_value, in_sda_in};
        want = bus_tick(seen);
        expected_ticks.push_back(want);
        if (want.done_res) begin
          txn_done++;
          if (hk == KIND_READ) txn_reads++;
          if (want.ack_error) txn_ack_err++;
        end
      end
      if (!push || !full) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= gap_pct) begin
          nxt = pending_ticks.pop_front();
          push <= 1'b1;
          in_request <= nxt.request;
          in_kind <= nxt.kind;
          in_register_address <= nxt.register_address;
          in_write_value <= nxt.write_value;
          in_sda_in <= nxt.sda_in;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch_words
    res_t got;
    res_t want;
    int   stall_pct;
    int   hold_nxt;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      stall_pct = (idle_mode == IDLE_RECV) ? 71 : (idle_mode == IDLE_BOTH) ? 9 : 0;
      hold_nxt = (hold_left != 0) ? hold_left - 1 : 0;
      if (pop && !empty) begin
        got = {out_scl, out_sda_out, out_sda_drive, out_busy_res, out_done_res,
               out_ack_error, out_read_value};
        if (expected_ticks.size() == 0) begin
          $display("%0t: result word mismatch, expected none, got %h", $time, got);
          mismatches++;
        end else begin
          want = expected_ticks.pop_front();
          check_field("scl", 8'(want.scl), 8'(got.scl));
          check_field("sda_out", 8'(want.sda_out), 8'(got.sda_out));
          check_field("sda_drive", 8'(want.sda_drive), 8'(got.sda_drive));
          check_field("busy", 8'(want.busy_res), 8'(got.busy_res));
          check_field("done", 8'(want.done_res), 8'(got.done_res));
          check_field("ack_error", 8'(want.ack_error), 8'(got.ack_error));
          check_field("read_value", want.read_value, got.read_value);
        end
        words_seen++;
        if (words_seen == hold_at) hold_nxt = HOLD_LEN;
      end
      hold_left = hold_nxt;
      pop <= (hold_nxt == 0) && ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic pick_sda(input int mode);
    case (mode)
      SDA_LOW:         return 1'b0;
      SDA_HIGH:        return 1'b1;
      SDA_MOSTLY_LOW:  return ($urandom_range(7) == 0);
      SDA_MOSTLY_HIGH: return ($urandom_range(7) != 0);
      default:         return 1'($urandom_range(1));
    endcase
  endfunction

  function automatic tick_t rand_tick(input int mode);
    tick_t t;
    t.request = ($urandom_range(3) == 0);
    t.kind = 1'($urandom_range(1));
    t.register_address = 8'($urandom_range(255));
    t.write_value = 8'($urandom_range(255));
    t.sda_in = pick_sda(mode);
    return t;
  endfunction

  // wait for the sequencer to return to idle, feeding quiet ticks meanwhile
  task automatic run_idle(input int mode);
    tick_t t;
    logic  busy;
    busy = 1'b1;
    while (busy) begin
      @(negedge clk);
      while (pending_ticks.size() != 0 || push) @(negedge clk);
      if (ph == P_IDLE) begin
        busy = 1'b0;
      end else begin
        repeat (32) begin
          t = '0;
          t.sda_in = pick_sda(mode);
          pending_ticks.push_back(t);
        end
      end
    end
  endtask

  task automatic settle();
    @(negedge clk);
    while (pending_ticks.size() != 0 || push || expected_ticks.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_DEVICE_ADDRESS: dev_addr = val[7:0];
      CFG_HALF_PERIOD:    half_len = val;
      CFG_GAP:            gap_len = val;
      default: ;
    endcase
  endtask

  task automatic set_bus(input logic [7:0] dev, input logic [15:0] half,
                         input logic [15:0] gap);
    cfg_write(CFG_DEVICE_ADDRESS, {8'd0, dev});
    cfg_write(CFG_HALF_PERIOD, half);
    cfg_write(CFG_GAP, gap);
    cfg_wen <= 1'b0;
  endtask

  // request, then a second request that lands while busy
  task automatic queue_req(input logic kind, input logic [7:0] reg_addr,
                           input logic [7:0] val, input int mode);
    tick_t t;
    t.request = 1'b1;
    t.kind = kind;
    t.register_address = reg_addr;
    t.write_value = val;
    t.sda_in = pick_sda(mode);
    pending_ticks.push_back(t);
    t.kind = ~kind;
    t.register_address = ~reg_addr;
    t.write_value = ~val;
    t.sda_in = pick_sda(mode);
    pending_ticks.push_back(t);
  endtask

  // request, a busy request, then quiet ticks to the end
  task automatic start_txn(input logic kind, input logic [7:0] reg_addr,
                           input logic [7:0] val, input int mode);
    queue_req(kind, reg_addr, val, mode);
    run_idle(mode);
  endtask

  initial begin : main_seq
    tick_t t;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // start under reset settings, then retime the bus mid-transaction
    idle_mode = IDLE_NONE;
    queue_req(KIND_WRITE, 8'h3C, 8'hA5, SDA_LOW);
    repeat (98) begin
      t = '0;
      t.sda_in = pick_sda(SDA_LOW);
      pending_ticks.push_back(t);
    end
    settle();
    set_bus(8'h00, 16'd1, 16'd1);
    run_idle(SDA_LOW);

    start_txn(KIND_WRITE, 8'hFF, 8'h00, SDA_LOW);
    hold_at = words_seen + 8;
    start_txn(KIND_WRITE, 8'h00, 8'hFF, SDA_HIGH);
    idle_mode = IDLE_SEND;
    start_txn(KIND_READ, 8'hFF, 8'h00, SDA_HIGH);
    idle_mode = IDLE_BOTH;
    start_txn(KIND_READ, 8'h00, 8'hFF, SDA_RAND);
    settle();

    idle_mode = IDLE_RECV;
    set_bus(8'hFF, 16'd0, 16'd0);
    start_txn(KIND_WRITE, 8'h5A, 8'hC3, SDA_RAND);
    start_txn(KIND_READ, 8'hA5, 8'h3C, SDA_LOW);
    settle();

    idle_mode = IDLE_NONE;
    set_bus(8'h80, 16'd2, 16'd5);
    start_txn(KIND_WRITE, 8'h81, 8'h7E, SDA_MOSTLY_LOW);
    settle();

    for (int k = 0; k < RAND_PHASES; k++) begin
      idle_mode = k % 4;
      set_bus(8'($urandom_range(255)), 16'($urandom_range(1, 2)),
              16'($urandom_range(1, 3)));
      repeat (RAND_ITEMS) pending_ticks.push_back(rand_tick(SDA_RAND + (k % 3)));
      run_idle(SDA_RAND);
      settle();
    end

    idle_mode = IDLE_BOTH;
    set_bus(8'hFE, 16'hFFFF, 16'hFFFF);
    t = rand_tick(SDA_RAND);
    t.request = 1'b1;
    pending_ticks.push_back(t);
    repeat (39) pending_ticks.push_back(rand_tick(SDA_RAND));
    settle();
    repeat (8) @(posedge clk);

    $display("Checked %0d results over %0d finished transactions (%0d reads, %0d ack errors).",
             words_seen, txn_done, txn_reads, txn_ack_err);
    $display("Phase lengths ran from zero to 65535 ticks with mixed idling; %0d mismatches.",
             mismatches);
    if (mismatches == 0 && expected_ticks.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Timeout after %0d cycles", LIMIT_CYCLES);
    $display("TEST FAILED");
    $finish;
  end

endmodule
